// ===== rtl/gko_pkg.sv =====
// ----------------------------------------------------------------------------
// gko_pkg
// Shared types, constants and tables for the gripper opening kinematics block.
// ----------------------------------------------------------------------------
package gko_pkg;

  // parameter defaults
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;

  // fixed widths
  localparam int WFRAC      = 30;
  localparam int ATAN_LEN   = 24;
  localparam int CW         = 34;
  localparam int SW         = 33;
  localparam int LINK_W     = 18;
  localparam int OFS_W      = 19;
  localparam int DIST_W     = 20;
  localparam int ANG_W      = 16;
  localparam int MAG_W      = 21;
  localparam int QW         = 31;
  localparam int RADW       = 62;
  localparam int MOD_STEPS  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 19;

  // pipeline depth of each section
  localparam int FRONT_STAGES = MOD_STEPS + 5;
  localparam int ROOT_STAGES  = 2 * QW + 3;
  localparam int BACK_STAGES  = 4;

  // Q30 angle constants
  localparam logic signed [63:0] Q_PI      = 64'sd3373259426;
  localparam logic signed [63:0] Q_HALF_PI = 64'sd1686629713;
  localparam logic signed [63:0] Q_TWO_PI  = 64'sd6746518852;
  localparam logic signed [63:0] Q_GAIN    = 64'sd652032874;

  // register reset values
  localparam logic [LINK_W-1:0]       LINK_RST = 18'd70000;
  localparam logic signed [OFS_W-1:0] OFS_RST  = 19'sd2194;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINK   = 1'b0,
    CFG_OFFSET = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] motor_angle;
    logic signed [15:0] left_spring_angle;
    logic signed [15:0] right_spring_angle;
    logic signed [19:0] target_distance;
  } in_data_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] opening_distance;
    logic signed [ANG_W-1:0]  joint_angle;
    logic                     out_of_range;
  } out_data_t;

  // item leaving the angle reduction front end
  typedef struct packed {
    logic                    vld;
    logic                    mode;
    logic                    flag;
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic signed [CW-1:0]    z1;
    logic signed [CW-1:0]    z2;
  } item_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cord_t;

  // beat handed from cell to cell
  typedef struct packed {
    logic  vld;
    logic  mode;
    logic  flag;
    logic  neg;
    cord_t a;
    cord_t b;
  } cell_t;

  function automatic int cordic_len(input int stages);
    return (stages < ATAN_LEN) ? stages : ATAN_LEN;
  endfunction

  // atan(2^-i) in Q30
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/gripper_opening_kinematics.sv =====
// ----------------------------------------------------------------------------
// gripper_opening_kinematics
// Forward: opening = link * (sin(m+l) + sin(m+r)) + 2*offset.
// Inverse: angle = asin((distance/2 - offset) / link), clamped and flagged.
// ----------------------------------------------------------------------------
//  channel   ports                              beat taken when
//  input     start, busy, in_data               start && !busy
//  result    out_valid, out_data                out_valid (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index,   cfg_valid && cfg_ready
//            cfg_wdata
//
// Fully pipelined: one item per cycle, busy stays low.
// Most of the pipeline depth is the bit-per-stage divider and square root.
// Synchronous active-low reset clears every stage valid and loads the
// register defaults. Results are strobed out once and never held.
// ----------------------------------------------------------------------------
module gripper_opening_kinematics #(
  parameter int CORDIC_STAGES   = gko_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = gko_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  gko_pkg::in_data_t                  in_data,
  output logic                               out_valid,
  output gko_pkg::out_data_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gko_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gko_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gko_pkg::*;

  localparam int NST = cordic_len(CORDIC_STAGES);
  localparam int SH  = WFRAC - ANGLE_FRAC_BITS;
  localparam int PW  = LINK_W + 1 + SW;
  localparam int TW  = PW - WFRAC;
  localparam int DW2 = TW + 1;

  localparam logic signed [CW-1:0]  HP_C    = CW'(Q_HALF_PI);
  localparam logic signed [CW-1:0]  ANG_RND = CW'(64'sd1 <<< (SH - 1));
  localparam logic signed [PW-1:0]  P_RND   = PW'(64'sd1 <<< (WFRAC - 1));
  localparam logic signed [CW-1:0]  ANG_MAX = CW'(32767);
  localparam logic signed [CW-1:0]  ANG_MIN = -CW'(32768);
  localparam logic signed [DW2-1:0] D_MAX   = DW2'(524287);
  localparam logic signed [DW2-1:0] D_MIN   = -DW2'(524288);

  // configuration registers
  logic [LINK_W-1:0]       link_r;
  logic signed [OFS_W-1:0] ofs_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= LINK_RST;
      ofs_r  <= OFS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LINK:   link_r <= cfg_wdata[LINK_W-1:0];
        CFG_OFFSET: ofs_r  <= signed'(cfg_wdata[OFS_W-1:0]);
        default: ;
      endcase
    end
  end

  // front end and root sections
  item_t fr_item;
  cell_t ch [NST+1];

  gko_front #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (start && !busy),
    .in_data (in_data),
    .link    (link_r),
    .offset  (ofs_r),
    .item_o  (fr_item)
  );

  gko_root u_root (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_i (fr_item),
    .link   (link_r),
    .cell_o (ch[0])
  );

  // chain of cordic cells
  generate
    for (genvar i = 0; i < NST; i++) begin : g_cell
      gko_cell #(
        .STAGE (i)
      ) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .cell_i (ch[i]),
        .cell_o (ch[i+1])
      );
    end
  endgenerate

  // back end: sum of sines or clamped arcsine
  logic                    b0_vld_r, b0_mode_r, b0_flag_r;
  logic signed [SW-1:0]    b0_sum_r;
  logic signed [CW-1:0]    b0_aq_r;
  logic                    b1_vld_r, b1_mode_r, b1_flag_r;
  logic signed [PW-1:0]    b1_p_r;
  logic signed [CW-1:0]    b1_ang_r;
  logic                    b2_vld_r, b2_mode_r, b2_flag_r;
  logic signed [TW-1:0]    b2_t_r;
  logic signed [ANG_W-1:0] b2_ang_r;
  logic                    out_valid_r;
  out_data_t               out_data_r, out_data_nxt;
  logic signed [DW2-1:0]   dist_full;
  logic                    ang_hi, ang_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_vld_r    <= 1'b0;
      b1_vld_r    <= 1'b0;
      b2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b0_vld_r    <= ch[NST].vld;
      b1_vld_r    <= b0_vld_r;
      b2_vld_r    <= b1_vld_r;
      out_valid_r <= b2_vld_r;
    end
  end

  // angle saturation
  assign ang_hi = b1_ang_r > ANG_MAX;
  assign ang_lo = b1_ang_r < ANG_MIN;

  always_ff @(posedge clk) begin
    b0_mode_r <= ch[NST].mode;
    b0_flag_r <= ch[NST].flag;
    b0_sum_r  <= SW'(ch[NST].a.y + ch[NST].b.y);
    b0_aq_r   <= ch[NST].flag ? (ch[NST].neg ? -HP_C : HP_C) : ch[NST].a.z;

    b1_mode_r <= b0_mode_r;
    b1_flag_r <= b0_flag_r;
    b1_p_r    <= PW'(signed'({1'b0, link_r})) * PW'(b0_sum_r);
    b1_ang_r  <= (b0_aq_r + ANG_RND) >>> SH;

    b2_mode_r <= b1_mode_r;
    b2_flag_r <= b1_flag_r || ang_hi || ang_lo;
    b2_t_r    <= TW'((b1_p_r + P_RND) >>> WFRAC);
    b2_ang_r  <= ang_hi ? ANG_W'(ANG_MAX) : (ang_lo ? ANG_W'(ANG_MIN) : ANG_W'(b1_ang_r));

    out_data_r <= out_data_nxt;
  end

  // opening with offset, saturate, pick mode
  always_comb begin
    dist_full    = DW2'(b2_t_r) + (DW2'(ofs_r) <<< 1);
    out_data_nxt = '0;
    if (b2_mode_r) begin
      out_data_nxt.joint_angle  = b2_ang_r;
      out_data_nxt.out_of_range = b2_flag_r;
    end else if (dist_full > D_MAX) begin
      out_data_nxt.opening_distance = DIST_W'(D_MAX);
      out_data_nxt.out_of_range     = 1'b1;
    end else if (dist_full < D_MIN) begin
      out_data_nxt.opening_distance = DIST_W'(D_MIN);
      out_data_nxt.out_of_range     = 1'b1;
    end else begin
      out_data_nxt.opening_distance = DIST_W'(dist_full);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/gko_front.sv =====
// ----------------------------------------------------------------------------
// gko_front
// Widens the angle sums, reduces them modulo 2*pi and folds them into
// [-pi/2, pi/2]; forms the arcsine numerator magnitude and range flag.
// ----------------------------------------------------------------------------
module gko_front #(
  parameter int ANGLE_FRAC_BITS = gko_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             take,
  input  gko_pkg::in_data_t                in_data,
  input  logic [gko_pkg::LINK_W-1:0]       link,
  input  logic signed [gko_pkg::OFS_W-1:0] offset,
  output gko_pkg::item_t                   item_o
);
  import gko_pkg::*;

  localparam int SH      = WFRAC - ANGLE_FRAC_BITS;
  localparam int AW      = (SH + 18 > 40) ? SH + 18 : 40;
  localparam int NS      = FRONT_STAGES;
  localparam int ST_MOD  = 2;
  localparam int ST_SIGN = ST_MOD + MOD_STEPS;
  localparam int ST_WRAP = ST_SIGN + 1;

  localparam logic signed [AW-1:0] PI_A  = AW'(Q_PI);
  localparam logic signed [AW-1:0] HP_A  = AW'(Q_HALF_PI);
  localparam logic signed [AW-1:0] TPI_A = AW'(Q_TWO_PI);

  typedef struct packed {
    logic                    vld;
    logic                    mode;
    logic                    flag;
    logic                    neg;
    logic                    s1;
    logic                    s2;
    logic signed [AW-1:0]    a1;
    logic signed [AW-1:0]    a2;
    logic signed [MAG_W-1:0] num;
    logic [MAG_W-1:0]        mag;
  } fr_t;

  fr_t st_r   [NS];
  fr_t st_nxt [NS];

  generate
    for (genvar g = 0; g < NS; g++) begin : g_st
      if (g == 0) begin : g_in
        // widen to Q30 and add, form numerator
        always_comb begin
          st_nxt[g]      = '0;
          st_nxt[g].vld  = take;
          st_nxt[g].mode = in_data.mode;
          st_nxt[g].a1   = (AW'(in_data.motor_angle) <<< SH) +
                           (AW'(in_data.left_spring_angle) <<< SH);
          st_nxt[g].a2   = (AW'(in_data.motor_angle) <<< SH) +
                           (AW'(in_data.right_spring_angle) <<< SH);
          st_nxt[g].num  = MAG_W'(in_data.target_distance) - (MAG_W'(offset) <<< 1);
        end
      end else if (g == 1) begin : g_abs
        // split into sign and magnitude
        always_comb begin
          st_nxt[g]     = st_r[g-1];
          st_nxt[g].s1  = st_r[g-1].a1 < 0;
          st_nxt[g].s2  = st_r[g-1].a2 < 0;
          st_nxt[g].a1  = st_nxt[g].s1 ? -st_r[g-1].a1 : st_r[g-1].a1;
          st_nxt[g].a2  = st_nxt[g].s2 ? -st_r[g-1].a2 : st_r[g-1].a2;
          st_nxt[g].neg = st_r[g-1].num < 0;
          st_nxt[g].mag = st_nxt[g].neg ? MAG_W'(-st_r[g-1].num) : MAG_W'(st_r[g-1].num);
        end
      end else if (g < ST_SIGN) begin : g_mod
        localparam logic signed [AW-1:0] K = AW'(Q_TWO_PI <<< (ST_SIGN - 1 - g));
        // one restoring step of the modulo
        always_comb begin
          st_nxt[g] = st_r[g-1];
          if (st_r[g-1].a1 >= K) st_nxt[g].a1 = st_r[g-1].a1 - K;
          if (st_r[g-1].a2 >= K) st_nxt[g].a2 = st_r[g-1].a2 - K;
          if (g == ST_MOD) begin
            st_nxt[g].flag = (link == '0) || (st_r[g-1].mag > MAG_W'({link, 1'b0}));
          end
        end
      end else if (g == ST_SIGN) begin : g_sign
        // restore sign, remainder takes the dividend sign
        always_comb begin
          st_nxt[g]    = st_r[g-1];
          st_nxt[g].a1 = st_r[g-1].s1 ? -st_r[g-1].a1 : st_r[g-1].a1;
          st_nxt[g].a2 = st_r[g-1].s2 ? -st_r[g-1].a2 : st_r[g-1].a2;
        end
      end else if (g == ST_WRAP) begin : g_wrap
        // wrap into [-pi, pi)
        always_comb begin
          st_nxt[g] = st_r[g-1];
          if (st_r[g-1].a1 >= PI_A) st_nxt[g].a1 = st_r[g-1].a1 - TPI_A;
          else if (st_r[g-1].a1 < -PI_A) st_nxt[g].a1 = st_r[g-1].a1 + TPI_A;
          if (st_r[g-1].a2 >= PI_A) st_nxt[g].a2 = st_r[g-1].a2 - TPI_A;
          else if (st_r[g-1].a2 < -PI_A) st_nxt[g].a2 = st_r[g-1].a2 + TPI_A;
        end
      end else begin : g_fold
        // fold onto [-pi/2, pi/2] with sin(pi - a) = sin(a)
        always_comb begin
          st_nxt[g] = st_r[g-1];
          if (st_r[g-1].a1 > HP_A) st_nxt[g].a1 = PI_A - st_r[g-1].a1;
          else if (st_r[g-1].a1 < -HP_A) st_nxt[g].a1 = -PI_A - st_r[g-1].a1;
          if (st_r[g-1].a2 > HP_A) st_nxt[g].a2 = PI_A - st_r[g-1].a2;
          else if (st_r[g-1].a2 < -HP_A) st_nxt[g].a2 = -PI_A - st_r[g-1].a2;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          st_r[g].vld <= 1'b0;
        end else begin
          st_r[g] <= st_nxt[g];
        end
      end
    end
  endgenerate

  // hand off to the root section
  always_comb begin
    item_o.vld  = st_r[NS-1].vld;
    item_o.mode = st_r[NS-1].mode;
    item_o.flag = st_r[NS-1].flag;
    item_o.neg  = st_r[NS-1].neg;
    item_o.mag  = st_r[NS-1].mag;
    item_o.z1   = CW'(st_r[NS-1].a1);
    item_o.z2   = CW'(st_r[NS-1].a2);
  end

endmodule

// ===== rtl/gko_root.sv =====
// ----------------------------------------------------------------------------
// gko_root
// Arcsine argument: ratio by a one-bit-per-stage divider, then the cosine
// leg sqrt(1 - r*r) by a one-bit-per-stage square root; loads the cells.
// ----------------------------------------------------------------------------
module gko_root (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gko_pkg::item_t             item_i,
  input  logic [gko_pkg::LINK_W-1:0] link,
  output gko_pkg::cell_t             cell_o
);
  import gko_pkg::*;

  logic [MAG_W-1:0] den;
  assign den = MAG_W'({link, 1'b0});

  // divider stages
  item_t            dv_it_r  [QW];
  logic [MAG_W-1:0] dv_rem_r [QW];
  logic [QW-1:0]    dv_quo_r [QW];

  generate
    for (genvar g = 0; g < QW; g++) begin : g_div
      item_t            it_in;
      logic [MAG_W-1:0] rem_sh;
      logic [MAG_W-1:0] rem_nxt;
      logic [QW-1:0]    quo_in;
      logic             ge;

      if (g == 0) begin : g_first
        assign it_in  = item_i;
        assign rem_sh = item_i.mag;
        assign quo_in = '0;
      end else begin : g_next
        assign it_in  = dv_it_r[g-1];
        assign rem_sh = {dv_rem_r[g-1][MAG_W-2:0], 1'b0};
        assign quo_in = dv_quo_r[g-1];
      end

      // compare and subtract, one quotient bit
      assign ge      = rem_sh >= den;
      assign rem_nxt = ge ? rem_sh - den : rem_sh;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_it_r[g].vld <= 1'b0;
        end else begin
          dv_it_r[g] <= it_in;
        end
      end

      always_ff @(posedge clk) begin
        dv_rem_r[g] <= rem_nxt;
        dv_quo_r[g] <= {quo_in[QW-2:0], ge};
      end
    end
  endgenerate

  // square of the ratio, then radicand
  item_t           sq_it_r, rd_it_r;
  logic [QW-1:0]   sq_q_r, rd_q_r;
  logic [RADW-1:0] sq_r, rd_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_it_r.vld <= 1'b0;
      rd_it_r.vld <= 1'b0;
    end else begin
      sq_it_r <= dv_it_r[QW-1];
      rd_it_r <= sq_it_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_q_r <= dv_quo_r[QW-1];
    sq_r   <= RADW'(dv_quo_r[QW-1]) * RADW'(dv_quo_r[QW-1]);
    rd_q_r <= sq_q_r;
    rd_n_r <= (RADW'(1) << (2 * WFRAC)) - sq_r;
  end

  // square root stages
  item_t           rt_it_r  [QW];
  logic [QW-1:0]   rt_q_r   [QW];
  logic [RADW-1:0] rt_n_r   [QW];
  logic [RADW-1:0] rt_res_r [QW];

  generate
    for (genvar k = 0; k < QW; k++) begin : g_sqrt
      localparam logic [RADW-1:0] BITV = RADW'(1) << (2 * (QW - 1 - k));
      item_t           it_in;
      logic [QW-1:0]   q_in;
      logic [RADW-1:0] n_in;
      logic [RADW-1:0] res_in;
      logic [RADW-1:0] trial;
      logic            ge;

      if (k == 0) begin : g_first
        assign it_in  = rd_it_r;
        assign q_in   = rd_q_r;
        assign n_in   = rd_n_r;
        assign res_in = '0;
      end else begin : g_next
        assign it_in  = rt_it_r[k-1];
        assign q_in   = rt_q_r[k-1];
        assign n_in   = rt_n_r[k-1];
        assign res_in = rt_res_r[k-1];
      end

      assign trial = res_in + BITV;
      assign ge    = n_in >= trial;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          rt_it_r[k].vld <= 1'b0;
        end else begin
          rt_it_r[k] <= it_in;
        end
      end

      always_ff @(posedge clk) begin
        rt_q_r[k]   <= q_in;
        rt_n_r[k]   <= ge ? n_in - trial : n_in;
        rt_res_r[k] <= ge ? (res_in >> 1) + BITV : res_in >> 1;
      end
    end
  endgenerate

  // load the first cell
  cell_t                cell_r, cell_nxt;
  logic signed [CW-1:0] q_s;
  item_t                it_l;

  assign it_l = rt_it_r[QW-1];
  assign q_s  = signed'(CW'(rt_q_r[QW-1]));

  always_comb begin
    cell_nxt.vld  = it_l.vld;
    cell_nxt.mode = it_l.mode;
    cell_nxt.flag = it_l.flag;
    cell_nxt.neg  = it_l.neg;
    cell_nxt.b.x  = CW'(Q_GAIN);
    cell_nxt.b.y  = '0;
    cell_nxt.b.z  = it_l.z2;
    if (it_l.mode) begin
      cell_nxt.a.x = signed'(CW'(rt_res_r[QW-1][QW-1:0]));
      cell_nxt.a.y = it_l.neg ? -q_s : q_s;
      cell_nxt.a.z = '0;
    end else begin
      cell_nxt.a.x = CW'(Q_GAIN);
      cell_nxt.a.y = '0;
      cell_nxt.a.z = it_l.z1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

// ===== rtl/gko_cell.sv =====
// ----------------------------------------------------------------------------
// gko_cell
// One CORDIC micro-rotation on two lanes. Lane a rotates (sine) or vectors
// (arcsine) by mode; lane b always rotates.
// ----------------------------------------------------------------------------
module gko_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  gko_pkg::cell_t cell_i,
  output gko_pkg::cell_t cell_o
);
  import gko_pkg::*;

  localparam logic signed [CW-1:0] ANG = atan_q30(STAGE);

  cell_t cell_r, cell_nxt;
  logic  pos_a, pos_b;

  // micro-rotation, direction from z or from y
  always_comb begin
    cell_nxt = cell_i;
    pos_a    = cell_i.mode ? (cell_i.a.y < 0) : (cell_i.a.z >= 0);
    pos_b    = cell_i.b.z >= 0;
    if (pos_a) begin
      cell_nxt.a.x = cell_i.a.x - (cell_i.a.y >>> STAGE);
      cell_nxt.a.y = cell_i.a.y + (cell_i.a.x >>> STAGE);
      cell_nxt.a.z = cell_i.a.z - ANG;
    end else begin
      cell_nxt.a.x = cell_i.a.x + (cell_i.a.y >>> STAGE);
      cell_nxt.a.y = cell_i.a.y - (cell_i.a.x >>> STAGE);
      cell_nxt.a.z = cell_i.a.z + ANG;
    end
    if (pos_b) begin
      cell_nxt.b.x = cell_i.b.x - (cell_i.b.y >>> STAGE);
      cell_nxt.b.y = cell_i.b.y + (cell_i.b.x >>> STAGE);
      cell_nxt.b.z = cell_i.b.z - ANG;
    end else begin
      cell_nxt.b.x = cell_i.b.x + (cell_i.b.y >>> STAGE);
      cell_nxt.b.y = cell_i.b.y - (cell_i.b.x >>> STAGE);
      cell_nxt.b.z = cell_i.b.z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

// ===== rtl/gko_checker.sv =====
// ----------------------------------------------------------------------------
// gko_assertions
// Port-level checks on the result strobe timing and result contents.
// ----------------------------------------------------------------------------
module gko_assertions #(
  parameter int CORDIC_STAGES = gko_pkg::CORDIC_STAGES_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input gko_pkg::out_data_t out_data
);
  import gko_pkg::*;

  localparam int LAT = FRONT_STAGES + ROOT_STAGES + cordic_len(CORDIC_STAGES) + BACK_STAGES;

  // no strobe right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // every accepted beat yields a result after the pipeline latency
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat produced no result");

  // no result without an accepted beat
  a_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LAT))
    else $error("result without accepted beat");

  // only one of the two result fields is used
  a_one_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.joint_angle == '0 || out_data.opening_distance == '0))
    else $error("both result fields nonzero");

endmodule

bind gripper_opening_kinematics gko_assertions #(
  .CORDIC_STAGES (CORDIC_STAGES)
) u_gko_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
